// ===== src/gmde_pkg.sv =====
// Shared types and constants for the gray morphology dilate/erode block.
// No dependencies; imported by gray_morph_dilate_erode.
package gmde_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ROW,
        ST_COL,
        ST_COLEND,
        ST_FIN
    } state_t;

    // Maximum for dilate, minimum for erode.
    function automatic logic [PIX_W-1:0] combine(
        input logic             mode,
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        logic [PIX_W-1:0] r;
        if (mode == MODE_ERODE)
        begin
            r = (a < b) ? a : b;
        end
        else
        begin
            r = (a > b) ? a : b;
        end
        return r;
    endfunction

endpackage

// ===== src/gray_morph_dilate_erode.sv =====
// Top level of the gray morphology dilate/erode filter: row pass over a
// shift window, column pass over a row-result line store. Uses gmde_pkg.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata: pixel_in, tuser: kind
// m_axis    out  tvalid/tready        tdata: pixel_out, tlast: frame_end
// cfg       in   cfg_we (no wait)     cfg_index, cfg_data
//
// One item at a time: accept, decide, then a row combine over up to 2r+1 taps
// of the window register and up to 2r+1 reads of the line store (one read
// port), a column drain state and a finish state.
// Reset clears control state and the window; the line store is not cleared.
// A finished result waits in the output register while the next item runs;
// the finish cycle only stalls when that register is still full.
module gray_morph_dilate_erode
    import gmde_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
    input  logic                 s_axis_tuser,   // [0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                               + MAX_RADIUS + 1);
    localparam int S  = 2 * MAX_RADIUS;
    localparam int SW = $clog2(S);
    localparam int L  = 2 * MAX_RADIUS + 1;
    localparam int LW = $clog2(L);
    localparam int AW = $clog2(S * MAX_WIDTH);

    state_t state_reg, state_next;

    logic [3:0]  radius_reg;
    logic        mode_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    logic [RW-1:0] eff_r;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    logic [NW-1:0] n_reg;
    logic [CW-1:0] fx_reg, ox_reg;
    logic [HW-1:0] fy_reg, oy_reg;
    logic [SW-1:0] fslot_reg, oslot_reg;

    logic          kind_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [NW-1:0] total_reg, lag_reg;
    logic          fresh_flag_reg, emit_reg, last_reg;
    logic [LW-1:0] off_cur_reg, off_hi_reg;
    logic [HW-1:0] y_cur_reg, y1_reg;
    logic [SW-1:0] slot_cur_reg;
    logic [PIX_W-1:0] acc_row_reg, acc_col_reg, rdata_reg;
    logic          pend_reg, pend_fresh_reg;
    logic [PIX_W-1:0] win_reg [L];

    logic          out_valid_reg, out_last_reg;
    logic [PIX_W-1:0] out_pix_reg;

    logic [PIX_W-1:0] mem [S * MAX_WIDTH];

    // decide-stage terms
    logic          d_in_frame, d_ignore, d_fresh, d_emit, d_last;
    logic [NW-1:0] d_nr, d_no;
    logic [WW-1:0] d_right, d_rmin;
    logic [CW-1:0] d_lmin;
    logic [LW-1:0] d_off_lo, d_off_hi;
    logic [HW-1:0] d_dist, d_y0, d_y1;
    logic [HW:0]   d_ysum;
    logic [SW:0]   d_wrap;
    logic [SW-1:0] d_slot0;
    logic [PIX_W-1:0] d_val, ident;

    logic          mem_we, mem_re, fin_go;
    logic [AW-1:0] waddr, raddr;

    assign eff_r = (radius_reg > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    assign eff_w = (width_reg == '0) ? WW'(1)
                 : ((width_reg > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg));
    assign eff_h = (height_reg == '0) ? HW'(1)
                 : ((height_reg > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg));
    assign ident = (mode_reg == MODE_ERODE) ? PIX_MAX : PIX_MIN;

    always_comb
    begin
        d_in_frame = n_reg < total_reg;
        d_ignore   = d_in_frame && (kind_reg == KIND_DRAIN);
        d_val      = d_in_frame ? pix_reg : PIX_MIN;
        d_nr       = n_reg - NW'(eff_r);
        d_fresh    = (n_reg >= NW'(eff_r)) && (d_nr < total_reg);
        d_no       = n_reg - lag_reg;
        d_emit     = (n_reg >= lag_reg) && (d_no < total_reg);
        d_last     = d_no == (total_reg - NW'(1));
        // row window span in offsets from the newest item
        d_right    = WW'(eff_w - WW'(1)) - WW'(fx_reg);
        d_rmin     = (d_right < WW'(eff_r)) ? d_right : WW'(eff_r);
        d_lmin     = (fx_reg < CW'(eff_r)) ? fx_reg : CW'(eff_r);
        d_off_lo   = LW'(eff_r) - LW'(d_rmin);
        d_off_hi   = LW'(eff_r) + LW'(d_lmin);
        // column span, cut at the frame borders
        d_dist     = (oy_reg > HW'(eff_r)) ? HW'(eff_r) : oy_reg;
        d_y0       = oy_reg - d_dist;
        d_ysum     = (HW + 1)'(oy_reg) + (HW + 1)'(eff_r);
        d_y1       = (d_ysum < (HW + 1)'(eff_h)) ? HW'(d_ysum) : HW'(eff_h - HW'(1));
        d_wrap     = (SW + 1)'(oslot_reg) + (SW + 1)'(S) - (SW + 1)'(d_dist);
        d_slot0    = (HW'(oslot_reg) >= d_dist) ? SW'(HW'(oslot_reg) - d_dist)
                                                : SW'(d_wrap);
    end

    assign fin_go = !emit_reg || !out_valid_reg || m_axis_tready;
    assign waddr  = AW'(fslot_reg) * AW'(MAX_WIDTH) + AW'(fx_reg);
    assign raddr  = AW'(slot_cur_reg) * AW'(MAX_WIDTH) + AW'(ox_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (d_ignore)
                begin
                    state_next = ST_IDLE;
                end
                else if (d_fresh)
                begin
                    state_next = ST_ROW;
                end
                else if (d_emit)
                begin
                    state_next = ST_COL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_ROW:
            begin
                if (off_cur_reg == off_hi_reg)
                begin
                    state_next = emit_reg ? ST_COL : ST_FIN;
                end
            end
            ST_COL:
            begin
                if (y_cur_reg == y1_reg)
                begin
                    state_next = ST_COLEND;
                end
            end
            ST_COLEND:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_COL:    mem_re = 1'b1;
            ST_FIN:    mem_we = fresh_flag_reg;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

    // line store: read before write within an item, so the fresh row
    // result lands after the column pass has seen the old slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= acc_row_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            radius_reg     <= 4'd0;
            mode_reg       <= MODE_DILATE;
            width_reg      <= 11'd1024;
            height_reg     <= 13'd1024;
            n_reg          <= '0;
            fx_reg         <= '0;
            fy_reg         <= '0;
            fslot_reg      <= '0;
            ox_reg         <= '0;
            oy_reg         <= '0;
            oslot_reg      <= '0;
            fresh_flag_reg <= 1'b0;
            emit_reg       <= 1'b0;
            last_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < L; i++)
            begin
                win_reg[i] <= PIX_MIN;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_COL);

            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_DECIDE)
            begin
                fresh_flag_reg <= d_fresh;
                emit_reg       <= d_emit;
                last_reg       <= d_emit && d_last;
                if (!d_ignore)
                begin
                    for (int i = L - 1; i > 0; i--)
                    begin
                        win_reg[i] <= win_reg[i-1];
                    end
                    win_reg[0] <= d_val;
                end
            end

            if ((state_reg == ST_FIN) && fin_go)
            begin
                if (emit_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                if (last_reg)
                begin
                    n_reg     <= '0;
                    fx_reg    <= '0;
                    fy_reg    <= '0;
                    fslot_reg <= '0;
                    ox_reg    <= '0;
                    oy_reg    <= '0;
                    oslot_reg <= '0;
                end
                else
                begin
                    n_reg <= n_reg + NW'(1);
                    if (fresh_flag_reg)
                    begin
                        if (WW'(fx_reg) == WW'(eff_w - WW'(1)))
                        begin
                            fx_reg    <= '0;
                            fy_reg    <= fy_reg + HW'(1);
                            fslot_reg <= (fslot_reg == SW'(S - 1)) ? '0
                                                                  : fslot_reg + SW'(1);
                        end
                        else
                        begin
                            fx_reg <= fx_reg + CW'(1);
                        end
                    end
                    if (emit_reg)
                    begin
                        if (WW'(ox_reg) == WW'(eff_w - WW'(1)))
                        begin
                            ox_reg    <= '0;
                            oy_reg    <= oy_reg + HW'(1);
                            oslot_reg <= (oslot_reg == SW'(S - 1)) ? '0
                                                                  : oslot_reg + SW'(1);
                        end
                        else
                        begin
                            ox_reg <= ox_reg + CW'(1);
                        end
                    end
                end
            end

            // any register write drops the frame in progress
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_data[3:0];
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data[12:0];
                    default:    radius_reg <= radius_reg;
                endcase
                n_reg     <= '0;
                fx_reg    <= '0;
                fy_reg    <= '0;
                fslot_reg <= '0;
                ox_reg    <= '0;
                oy_reg    <= '0;
                oslot_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            acc_col_reg <= combine(mode_reg, acc_col_reg,
                                   pend_fresh_reg ? acc_row_reg : rdata_reg);
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_reg  <= s_axis_tuser;
                    pix_reg   <= s_axis_tdata;
                    total_reg <= NW'(eff_w) * NW'(eff_h);
                    lag_reg   <= NW'(eff_r) * NW'(eff_w) + NW'(eff_r);
                end
            end
            ST_DECIDE:
            begin
                acc_row_reg  <= ident;
                acc_col_reg  <= ident;
                off_cur_reg  <= d_off_lo;
                off_hi_reg   <= d_off_hi;
                y_cur_reg    <= d_y0;
                y1_reg       <= d_y1;
                slot_cur_reg <= d_slot0;
            end
            ST_ROW:
            begin
                acc_row_reg <= combine(mode_reg, acc_row_reg, win_reg[off_cur_reg]);
                off_cur_reg <= off_cur_reg + LW'(1);
            end
            ST_COL:
            begin
                // the newest row comes straight from the row pass
                pend_fresh_reg <= fresh_flag_reg && (y_cur_reg == fy_reg)
                                  && (ox_reg == fx_reg);
                y_cur_reg      <= y_cur_reg + HW'(1);
                slot_cur_reg   <= (slot_cur_reg == SW'(S - 1)) ? '0
                                                             : slot_cur_reg + SW'(1);
            end
            ST_FIN:
            begin
                if (fin_go && emit_reg)
                begin
                    out_pix_reg  <= acc_col_reg;
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
                pend_fresh_reg <= 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    a_pend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_COL))
        else $error("line store data consumed without a read");

    a_row_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW) |-> (off_cur_reg <= off_hi_reg))
        else $error("row pass ran past its window span");

    a_col_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COL) |-> (y_cur_reg <= y1_reg))
        else $error("column pass ran past its last row");

    a_fcol_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (WW'(fx_reg) < eff_w) && (WW'(ox_reg) < eff_w))
        else $error("column counter beyond image width");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_pix_reg)))
        else $error("pending item lost before it was taken");
`endif

endmodule

// ===== verif/tb_gray_morph_dilate_erode.sv =====
// Self-checking testbench for gray_morph_dilate_erode: frames of random size,
// radius and mode are streamed in and each output pixel is checked against a
// behavioral predictor of the dilate/erode filter. Depends on src/gmde_pkg.sv.
module tb_gray_morph_dilate_erode;
    import gmde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW      = 1024;
    localparam int MAXH      = 4096;
    localparam int MAXR      = 8;
    localparam int LINE_ROWS = 2 * MAXR;
    localparam int WIN_TAPS  = 2 * MAXR + 1;
    // Leave a margin after the last output before touching registers.
    localparam int SETTLE    = 4 * MAXR + 30;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } filt_pix_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [PIX_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gray_morph_dilate_erode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor state
    logic [3:0]       radius_reg;
    logic             mode_reg;
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic [PIX_W-1:0] line_store [0:LINE_ROWS*MAXW-1];
    logic [PIX_W-1:0] row_taps [0:WIN_TAPS-1];
    int unsigned      pix_seen;

    filt_pix_t   pending_pix[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          holdoff_cycles;
    int          items_sent;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        if (mode_reg == MODE_ERODE)
            return (a < b) ? a : b;
        return (a > b) ? a : b;
    endfunction

    // Advance the filter model by one accepted item; queue any output it frees.
    task automatic predict_filter(input logic kind, input logic [PIX_W-1:0] pin);
        int unsigned r, w, h, total, lag, n, m, fy, fx, o, oy, ox, lo, hi, y0, y1, c, y;
        logic [PIX_W-1:0] ident, fresh, acc, val;
        logic have_fresh;
        filt_pix_t exp_pix;
        r = (radius_reg > MAXR) ? MAXR : radius_reg;
        w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAXH) ? MAXH : height_reg);
        total = w * h;
        lag = r * w + r;
        n = pix_seen;
        ident = (mode_reg == MODE_ERODE) ? PIX_MAX : PIX_MIN;
        fresh = ident;
        have_fresh = 1'b0;
        val = '0;
        fy = 0;
        fx = 0;
        if (n < total)
        begin
            if (kind == KIND_DRAIN)
                return;
            val = pin;
        end
        for (int k = WIN_TAPS - 1; k > 0; k--)
            row_taps[k] = row_taps[k-1];
        row_taps[0] = val;
        if (n >= r && n - r < total)
        begin
            m = n - r;
            fy = m / w;
            fx = m % w;
            lo = (fx > r) ? fx - r : 0;
            hi = (fx + r < w) ? fx + r : w - 1;
            for (c = lo; c <= hi; c++)
                fresh = pick(fresh, row_taps[r + fx - c]);
            have_fresh = 1'b1;
        end
        if (n >= lag && n - lag < total)
        begin
            o = n - lag;
            oy = o / w;
            ox = o % w;
            y0 = (oy > r) ? oy - r : 0;
            y1 = (oy + r < h) ? oy + r : h - 1;
            acc = ident;
            for (y = y0; y <= y1; y++)
            begin
                if (have_fresh && y == fy && ox == fx)
                    acc = pick(acc, fresh);
                else
                    acc = pick(acc, line_store[(y % LINE_ROWS) * MAXW + ox]);
            end
            exp_pix.pix = acc;
            exp_pix.last = (o == total - 1);
            pending_pix.push_back(exp_pix);
        end
        if (have_fresh)
            line_store[(fy % LINE_ROWS) * MAXW + fx] = fresh;
        pix_seen = n + 1;
        if (n >= lag && n - lag == total - 1)
            pix_seen = 0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Check each output item against the oldest expectation.
    always @(posedge clk)
    begin
        filt_pix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pix.size() == 0)
            begin
                report_mismatch("unexpected pixel", int'(m_axis_tdata), -1);
            end
            else
            begin
                want = pending_pix.pop_front();
                if (m_axis_tdata !== want.pix)
                    report_mismatch("pixel_out", int'(m_axis_tdata), int'(want.pix));
                if (m_axis_tlast !== want.last)
                    report_mismatch("frame_end", int'(m_axis_tlast), int'(want.last));
            end
        end
    end

    // Receiver: long hold-off when requested, else random stalls.
    always @(negedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Call at a falling edge; returns at a falling edge.
    task automatic send_item(input logic kind, input logic [PIX_W-1:0] pin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pin;
        s_axis_tuser = kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_filter(kind, pin);
        items_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pix.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_drained();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_RADIUS: radius_reg = value[3:0];
            REG_MODE:   mode_reg = value[0];
            REG_WIDTH:  width_reg = value[10:0];
            REG_HEIGHT: height_reg = value[12:0];
            default: ;
        endcase
        pix_seen = 0;
    endtask

    task automatic set_filter(input int unsigned r, input logic md,
                              input int unsigned w, input int unsigned h);
        write_reg(REG_RADIUS, r);
        write_reg(REG_MODE, 32'(md));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // One whole frame plus its flush. Early drains are ignored, and pixels in
    // the flush act as drains.
    task automatic run_frame(input int noise_pct);
        int unsigned r, w, h, lag;
        r = (radius_reg > MAXR) ? MAXR : radius_reg;
        w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAXH) ? MAXH : height_reg);
        lag = r * w + r;
        for (int unsigned i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
            send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
        end
        for (int unsigned i = 0; i < lag; i++)
            send_item($urandom_range(0, 3) == 0 ? KIND_PIXEL : KIND_DRAIN,
                      8'($urandom_range(0, 255)));
        // A stray drain after the frame has nothing to release.
        if ($urandom_range(0, 99) < noise_pct)
            send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        logic [PIX_W-1:0] pat [0:11];
        pat = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                8'h00, 8'h10, 8'hFF, 8'h33};
        for (int md = 0; md < 2; md++)
        begin
            set_filter(1, md[0], 4, 3);
            send_item(KIND_DRAIN, 8'hFF);
            for (int i = 0; i < 12; i++)
                send_item(KIND_PIXEL, pat[i]);
            send_item(KIND_DRAIN, 8'h00);
            send_item(KIND_PIXEL, 8'hFF);
            send_item(KIND_DRAIN, 8'h00);
            send_item(KIND_DRAIN, 8'h00);
            send_item(KIND_DRAIN, 8'h00);
        end
    endtask

    task automatic test_extremes();
        // Zero radius passes the pixels through, on a 3 by 2 frame.
        set_filter(0, MODE_DILATE, 3, 2);
        run_frame(10);
        // Radius above the limit, width and height of zero.
        set_filter(15, MODE_ERODE, 0, 0);
        run_frame(0);
        set_filter(15, MODE_DILATE, 5, 4);
        run_frame(10);
        // Widest row, width above the limit.
        set_filter(0, MODE_ERODE, 2047, 1);
        run_frame(0);
        // Single-column frame.
        set_filter(2, MODE_DILATE, 1, 40);
        run_frame(5);
    endtask

    task automatic test_random_frames(input int target, input bit squeeze);
        int start;
        start = items_sent;
        while (items_sent - start < target)
        begin
            set_filter($urandom_range(0, 9) == 0 ? $urandom_range(9, 15) : $urandom_range(0, MAXR),
                       1'($urandom_range(0, 1)), $urandom_range(1, 16), $urandom_range(1, 12));
            if (squeeze)
            begin
                squeeze = 1'b0;
                holdoff_cycles = 600;
            end
            run_frame(8);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_PIXEL;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        error_count = 0;
        holdoff_cycles = 0;
        items_sent = 0;
        send_idle_pct = 26;
        recv_idle_pct = 49;
        radius_reg = 0;
        mode_reg = MODE_DILATE;
        width_reg = 11'd1024;
        height_reg = 13'd1024;
        pix_seen = 0;
        for (int i = 0; i < LINE_ROWS * MAXW; i++)
            line_store[i] = '0;
        for (int i = 0; i < WIN_TAPS; i++)
            row_taps[i] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_extremes();
        test_random_frames(60, 1'b0);
        send_idle_pct = 49;
        recv_idle_pct = 26;
        test_random_frames(60, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(60, 1'b1);

        wait_drained();
        if (error_count == 0)
            $display("[gray_morph_dilate_erode] OK");
        else
            $display("[gray_morph_dilate_erode] ERROR");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("[gray_morph_dilate_erode] ERROR");
        $finish;
    end

endmodule
